// ===== rtl/core/raw_level_normalize_highlight_clamp_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the raw level normalizer
// Shared property wrappers with active-low reset masking.
// ---------------------------------------------------------------------------
`ifndef RAW_LEVEL_NORMALIZE_HIGHLIGHT_CLAMP_DEFINES_SVH
`define RAW_LEVEL_NORMALIZE_HIGHLIGHT_CLAMP_DEFINES_SVH

// same-cycle implication
`define RLNHC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rlnhc assertion failed");

// next-cycle implication
`define RLNHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rlnhc assertion failed");

`endif

// ===== rtl/core/rlnhc_pkg.sv =====
// ---------------------------------------------------------------------------
// rlnhc_pkg
// Shared types and constants of the raw level normalizer.
// ---------------------------------------------------------------------------
package rlnhc_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CH_W            = 16;
    localparam int NUM_CH          = 3;
    localparam int PIPE_DEPTH      = 8;

    localparam logic [1:0] CH0     = 2'd0;
    localparam logic [1:0] CH1     = 2'd1;
    localparam logic [1:0] CH2     = 2'd2;
    localparam logic [1:0] CH_NONE = 2'd3;

    localparam logic [47:0] RST_BLACK  = 48'h0000_0000_0000;
    localparam logic [47:0] RST_SCALE  = 48'h1000_1000_1000;
    localparam logic [47:0] RST_CAP    = 48'hFFFF_FFFF_FFFF;
    localparam logic [15:0] RST_WHITE  = 16'd65535;
    localparam logic [1:0]  RST_SAT    = CH2;
    localparam logic [15:0] RST_THRESH = 16'd58982;
    localparam logic [31:0] RST_RECIP  = 32'd655404;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    typedef enum logic [2:0] {
        CFG_BLACK  = 3'd0,
        CFG_SCALE  = 3'd1,
        CFG_CAP    = 3'd2,
        CFG_WHITE  = 3'd3,
        CFG_SAT    = 3'd4,
        CFG_THRESH = 3'd5,
        CFG_RECIP  = 3'd6
    } t_cfg_idx;

    typedef logic [NUM_CH-1:0][CH_W-1:0] t_pix;

    typedef struct packed {
        logic        en;
        logic [1:0]  sat;
        logic [16:0] s;
    } t_blend_ctl;

endpackage

// ===== rtl/core/raw_level_normalize_highlight_clamp.sv =====
// ---------------------------------------------------------------------------
// raw_level_normalize_highlight_clamp
// Per-pixel black/white normalization with highlight clamp toward a cap.
//
// Input beat: s_axis, tdata = {in_ch2, in_ch1, in_ch0}, 16 bits each.
// Output beat: m_axis, tdata = {out_ch2, out_ch1, out_ch0}, 16 bits each.
// One result beat per input beat, in order.
// Config: i_cfg_valid/o_cfg_ready with register index and data; write
// only while no beat is in flight. o_cfg_ready is always high.
// Throughput: one pixel per cycle while o_s_axis_tready is high. Path from input
// beat to o_m_axis_tvalid: 8 pipeline stages, set by the multiply chain of the
// smoothstep weight, plus the output register.
// A stall of m_axis freezes the pipeline only once the two-entry output
// buffer is full; o_s_axis_tready is low for exactly the cycles it stays full.
// Reset clears all valid bits and loads register defaults; no clearing pass.
// ---------------------------------------------------------------------------
`include "raw_level_normalize_highlight_clamp_defines.svh"

module raw_level_normalize_highlight_clamp #(
    parameter int SAMPLE_BITS = rlnhc_pkg::SAMPLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // in_ch0 [15:0], in_ch1 [31:16], in_ch2 [47:32]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // out_ch0 [15:0], out_ch1 [31:16], out_ch2 [47:32]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);
    import rlnhc_pkg::*;

    localparam logic [15:0] SAMPLE_MAX = 16'((32'd1 << SAMPLE_BITS) - 32'd1);

    logic [47:0] r_black;
    logic [47:0] r_scale;
    logic [47:0] r_cap;
    logic [15:0] r_white;
    logic [1:0]  r_sat;
    logic [15:0] r_thresh;
    logic [31:0] r_recip;
    logic [15:0] w_white;

    logic                  w_ce;
    logic                  w_in_acc;
    logic [PIPE_DEPTH-1:0] r_vld;
    t_pix                  w_n;
    t_pix                  w_pix_d;
    t_blend_ctl            w_ctl;
    t_pix                  w_res;

    logic w_push;
    logic w_pop;
    logic w_stall_push;
    logic r_out_valid;
    logic n_out_valid;
    logic r_skid_valid;
    logic n_skid_valid;
    logic w_load_out;
    logic w_load_skid;
    logic w_out_from_skid;
    t_pix r_out_data;
    t_pix r_skid_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_black  <= RST_BLACK;
            r_scale  <= RST_SCALE;
            r_cap    <= RST_CAP;
            r_white  <= RST_WHITE;
            r_sat    <= RST_SAT;
            r_thresh <= RST_THRESH;
            r_recip  <= RST_RECIP;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BLACK:  r_black  <= i_cfg_data;
                CFG_SCALE:  r_scale  <= i_cfg_data;
                CFG_CAP:    r_cap    <= i_cfg_data;
                CFG_WHITE:  r_white  <= i_cfg_data[15:0];
                CFG_SAT:    r_sat    <= i_cfg_data[1:0];
                CFG_THRESH: r_thresh <= i_cfg_data[15:0];
                CFG_RECIP:  r_recip  <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign w_white = (r_white > SAMPLE_MAX) ? SAMPLE_MAX : r_white;

    assign w_ce            = !r_skid_valid;
    assign o_s_axis_tready = w_ce;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], w_in_acc};
        end
    end

    for (genvar c = 0; c < NUM_CH; c++) begin : g_norm
        rlnhc_norm #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_norm (
            .i_clk   (i_clk),
            .i_ce    (w_ce),
            .i_x     (i_s_axis_tdata[CH_W*c +: CH_W]),
            .i_black (r_black[CH_W*c +: CH_W]),
            .i_scale (r_scale[CH_W*c +: CH_W]),
            .i_white (w_white),
            .o_n     (w_n[c])
        );
    end

    rlnhc_weight u_weight (
        .i_clk    (i_clk),
        .i_ce     (w_ce),
        .i_pix    (w_n),
        .i_sat    (r_sat),
        .i_thresh (r_thresh),
        .i_recip  (r_recip),
        .o_pix    (w_pix_d),
        .o_ctl    (w_ctl)
    );

    for (genvar c = 0; c < NUM_CH; c++) begin : g_blend
        rlnhc_blend u_blend (
            .i_clk   (i_clk),
            .i_ce    (w_ce),
            .i_pv    (w_pix_d[c]),
            .i_cap   (r_cap[CH_W*c +: CH_W]),
            .i_s     (w_ctl.s),
            .i_apply (w_ctl.en && (w_ctl.sat != 2'(c))),
            .o_res   (w_res[c])
        );
    end

    assign w_push       = w_ce && r_vld[PIPE_DEPTH-1];
    assign w_pop        = r_out_valid && i_m_axis_tready;
    assign w_stall_push = w_push && r_out_valid && !i_m_axis_tready;

    always_comb begin
        n_out_valid     = r_out_valid;
        n_skid_valid    = r_skid_valid;
        w_load_out      = 1'b0;
        w_load_skid     = 1'b0;
        w_out_from_skid = 1'b0;
        if (w_pop) begin
            if (r_skid_valid) begin
                w_load_out      = 1'b1;
                w_out_from_skid = 1'b1;
                n_skid_valid    = 1'b0;
            end else begin
                n_out_valid = w_push;
                w_load_out  = w_push;
            end
        end else if (!r_out_valid) begin
            n_out_valid = w_push;
            w_load_out  = w_push;
        end else if (w_push) begin
            n_skid_valid = 1'b1;
            w_load_skid  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data <= w_out_from_skid ? r_skid_data : w_res;
        end
        if (w_load_skid) begin
            r_skid_data <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `RLNHC_ASSERT_IMPL(a_skid_needs_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `RLNHC_ASSERT_NEXT(a_stall_fills_skid, i_clk, i_rst_n, w_stall_push, r_skid_valid)
    `RLNHC_ASSERT_NEXT(a_accept_enters_pipe, i_clk, i_rst_n, w_in_acc, r_vld[0])

endmodule

// ===== rtl/core/rlnhc_norm.sv =====
// ---------------------------------------------------------------------------
// rlnhc_norm
// One channel lane: black subtract, Q4.12 scale, round and clip to white.
// ---------------------------------------------------------------------------
module rlnhc_norm #(
    parameter int SAMPLE_BITS = rlnhc_pkg::SAMPLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_ce,
    input  logic [15:0] i_x,
    input  logic [15:0] i_black,
    input  logic [15:0] i_scale,
    input  logic [15:0] i_white,
    output logic [15:0] o_n
);
    import rlnhc_pkg::*;

    localparam logic [15:0] SAMPLE_MAX = 16'((32'd1 << SAMPLE_BITS) - 32'd1);

    logic [15:0] w_x;
    logic [15:0] w_d;
    logic [31:0] n_prod;
    logic        n_pos;
    logic [31:0] r_prod;
    logic        r_pos;
    logic [32:0] w_rnd;
    logic [20:0] w_q;
    logic [15:0] n_n;
    logic [15:0] r_n;

    assign w_x    = i_x & SAMPLE_MAX;
    assign w_d    = w_x - i_black;
    assign n_pos  = w_x > i_black;
    assign n_prod = {16'd0, w_d} * {16'd0, i_scale};

    assign w_rnd = {1'b0, r_prod} + 33'd2048;
    assign w_q   = w_rnd[32:12];

    always_comb begin
        if (!r_pos) begin
            n_n = '0;
        end else if (w_q > {5'd0, i_white}) begin
            n_n = i_white;
        end else begin
            n_n = w_q[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_prod <= n_prod;
            r_pos  <= n_pos;
            r_n    <= n_n;
        end
    end

    assign o_n = r_n;

endmodule

// ===== rtl/core/rlnhc_weight.sv =====
// ---------------------------------------------------------------------------
// rlnhc_weight
// Merge stage: pick the saturating channel, test the threshold and form
// the smoothstep blend weight; carry the pixel alongside.
// ---------------------------------------------------------------------------
module rlnhc_weight (
    input  logic                   i_clk,
    input  logic                   i_ce,
    input  rlnhc_pkg::t_pix        i_pix,
    input  logic [1:0]             i_sat,
    input  logic [15:0]            i_thresh,
    input  logic [31:0]            i_recip,
    output rlnhc_pkg::t_pix        o_pix,
    output rlnhc_pkg::t_blend_ctl  o_ctl
);
    import rlnhc_pkg::*;

    localparam int CARRY = 5;

    t_pix        r_pix [CARRY];
    logic        r_en  [CARRY];
    logic [1:0]  r_sat [CARRY];

    logic [15:0] w_nsat;
    logic        n_en;
    logic [15:0] r_diff;
    logic [47:0] r_t32;
    logic [32:0] w_t32c;
    logic [32:0] w_trnd;
    logic [16:0] n_t;
    logic [16:0] r_t;
    logic [33:0] r_tt;
    logic [32:0] w_urnd;
    logic [16:0] w_u;
    logic [17:0] w_f;
    logic [34:0] r_sp;
    logic [35:0] w_srnd;
    logic [19:0] w_sq;
    logic [16:0] n_s;
    logic [16:0] r_s;

    always_comb begin
        unique case (i_sat)
            CH0:     w_nsat = i_pix[0];
            CH1:     w_nsat = i_pix[1];
            default: w_nsat = i_pix[2];
        endcase
    end

    assign n_en = (i_sat != CH_NONE) && (w_nsat >= i_thresh);

    assign w_t32c = (r_t32 > 48'h1_0000_0000) ? 33'h1_0000_0000 : r_t32[32:0];
    assign w_trnd = w_t32c + 33'd32768;
    assign n_t    = w_trnd[32:16];

    assign w_urnd = r_tt[32:0] + 33'd32768;
    assign w_u    = w_urnd[32:16];
    assign w_f    = 18'd196608 - {r_t, 1'b0};

    assign w_srnd = {1'b0, r_sp} + 36'd32768;
    assign w_sq   = w_srnd[35:16];
    assign n_s    = (w_sq > {3'd0, ONE_Q16}) ? ONE_Q16 : w_sq[16:0];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_pix[0] <= i_pix;
            r_en[0]  <= n_en;
            r_sat[0] <= i_sat;
            for (int k = 1; k < CARRY; k++) begin
                r_pix[k] <= r_pix[k-1];
                r_en[k]  <= r_en[k-1];
                r_sat[k] <= r_sat[k-1];
            end
            r_diff <= w_nsat - i_thresh;
            r_t32  <= {32'd0, r_diff} * {16'd0, i_recip};
            r_t    <= n_t;
            r_tt   <= {17'd0, n_t} * {17'd0, n_t};
            r_sp   <= {18'd0, w_u} * {17'd0, w_f};
            r_s    <= n_s;
        end
    end

    assign o_pix     = r_pix[CARRY-1];
    assign o_ctl.en  = r_en[CARRY-1];
    assign o_ctl.sat = r_sat[CARRY-1];
    assign o_ctl.s   = r_s;

endmodule

// ===== rtl/core/rlnhc_blend.sv =====
// ---------------------------------------------------------------------------
// rlnhc_blend
// One channel lane: when applied, blend toward the cap and keep the lower of the two.
// ---------------------------------------------------------------------------
module rlnhc_blend (
    input  logic        i_clk,
    input  logic        i_ce,
    input  logic [15:0] i_pv,
    input  logic [15:0] i_cap,
    input  logic [16:0] i_s,
    input  logic        i_apply,
    output logic [15:0] o_res
);
    import rlnhc_pkg::*;

    logic [16:0] w_inv;
    logic [32:0] r_a;
    logic [32:0] r_b;
    logic [15:0] r_pv;
    logic        r_apply;
    logic [33:0] w_sum;
    logic [17:0] w_lim;

    assign w_inv = ONE_Q16 - i_s;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_a     <= {17'd0, i_pv} * {16'd0, w_inv};
            r_b     <= {17'd0, i_cap} * {16'd0, i_s};
            r_pv    <= i_pv;
            r_apply <= i_apply;
        end
    end

    assign w_sum = {1'b0, r_a} + {1'b0, r_b} + 34'd32768;
    assign w_lim = w_sum[33:16];
    assign o_res = (r_apply && (w_lim < {2'd0, r_pv})) ? w_lim[15:0] : r_pv;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for raw_level_normalize_highlight_clamp
// Streams three-channel raw pixels through the block and checks each returned
// pixel against an in-bench model of the level normalization and the
// smoothstep highlight clamp. Directed corner cases come first, then
// randomized register settings under several idle and stall patterns, and a
// long output hold-off that backs the pipeline up into its input.
// ----------------------------------------------------------------------------
module tb;
    import rlnhc_pkg::*;

    localparam logic [2:0]  CFG_SPARE   = 3'd7;
    localparam int          PERIOD_HI   = 2;
    localparam int          PERIOD_LO   = 2;
    localparam int          RESET_CYC   = 11;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          HOLD_CYC    = 300;
    localparam int          PHASE_PIX   = 220;
    localparam logic [63:0] UNIT        = 64'(ONE_Q16);

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [47:0] i_s_axis_tdata  = '0;
    logic        i_m_axis_tready = 1'b0;
    logic        i_cfg_valid     = 1'b0;
    logic [2:0]  i_cfg_index     = '0;
    logic [47:0] i_cfg_data      = '0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [47:0] o_m_axis_tdata;
    logic        o_cfg_ready;

    // register image as the block should hold it
    logic [47:0] reg_black  = RST_BLACK;
    logic [47:0] reg_scale  = RST_SCALE;
    logic [47:0] reg_cap    = RST_CAP;
    logic [15:0] reg_white  = RST_WHITE;
    logic [1:0]  reg_sat    = RST_SAT;
    logic [15:0] reg_thresh = RST_THRESH;
    logic [31:0] reg_recip  = RST_RECIP;

    t_pix pending_pix[$];
    int   mismatches     = 0;
    int   cycles         = 0;
    int   src_idle_pct   = 0;
    int   sink_stall_pct = 0;
    int   hold_reqs      = 0;
    int   hold_served    = 0;
    int   hold_left      = 0;

    raw_level_normalize_highlight_clamp u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // in_ch0, in_ch1, in_ch2
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // out_ch0, out_ch1, out_ch2
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #PERIOD_HI i_clk = 1'b1;
        #PERIOD_LO i_clk = 1'b0;
    end

    function automatic t_pix normalize_and_clamp(input t_pix raw);
        t_pix        n;
        logic [63:0] x, bl, p, d, t32, t, u, s, pv, cp, lim;
        for (int c = 0; c < NUM_CH; c++) begin
            x  = 64'(raw[c]);
            bl = 64'(reg_black[16*c +: 16]);
            if (x <= bl) begin
                n[c] = '0;
            end else begin
                p = ((x - bl) * 64'(reg_scale[16*c +: 16]) + 64'd2048) >> 12;
                if (p > 64'(reg_white))
                    p = 64'(reg_white);
                n[c] = p[15:0];
            end
        end
        if (reg_sat != CH_NONE && n[reg_sat] >= reg_thresh) begin
            d   = 64'(n[reg_sat]);
            d   = d - 64'(reg_thresh);
            t32 = d * 64'(reg_recip);
            if (t32 > (UNIT << 16))
                t32 = UNIT << 16;
            t = (t32 + 64'd32768) >> 16;
            u = (t * t + 64'd32768) >> 16;
            s = (u * (64'd3 * UNIT - 64'd2 * t) + 64'd32768) >> 16;
            if (s > UNIT)
                s = UNIT;
            for (int c = 0; c < NUM_CH; c++) begin
                if (2'(c) != reg_sat) begin
                    pv  = 64'(n[c]);
                    cp  = 64'(reg_cap[16*c +: 16]);
                    lim = (pv * (UNIT - s) + cp * s + 64'd32768) >> 16;
                    if (lim < pv)
                        n[c] = lim[15:0];
                end
            end
        end
        return n;
    endfunction

    // track register writes, predict accepted pixels, check returned pixels
    always @(posedge i_clk) begin : mon
        t_pix want;
        t_pix got;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = o_m_axis_tdata;
                if (pending_pix.size() == 0) begin
                    $display("%0t ERROR unexpected pixel %h", $time, got);
                    mismatches++;
                end else begin
                    want = pending_pix.pop_front();
                    for (int c = 0; c < NUM_CH; c++) begin
                        if (got[c] !== want[c]) begin
                            $display("%0t ERROR out_ch%0d expected %h actual %h",
                                     $time, c, want[c], got[c]);
                            mismatches++;
                        end
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready)
                pending_pix.push_back(normalize_and_clamp(i_s_axis_tdata));
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BLACK:  reg_black  = i_cfg_data;
                    CFG_SCALE:  reg_scale  = i_cfg_data;
                    CFG_CAP:    reg_cap    = i_cfg_data;
                    CFG_WHITE:  reg_white  = i_cfg_data[15:0];
                    CFG_SAT:    reg_sat    = i_cfg_data[1:0];
                    CFG_THRESH: reg_thresh = i_cfg_data[15:0];
                    CFG_RECIP:  reg_recip  = i_cfg_data[31:0];
                    default: ;
                endcase
            end
        end
    end

    // output side: random stalls, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_served != hold_reqs) begin
            hold_served = hold_reqs;
            hold_left   = HOLD_CYC;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic offer_pixel(input logic [15:0] ch0, ch1, ch2);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {ch2, ch1, ch0};
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
    endtask

    task automatic offer_random_pixel();
        logic [15:0] ch[3];
        for (int c = 0; c < NUM_CH; c++) begin
            case ($urandom_range(3))
                0:       ch[c] = 16'($urandom_range(65535));
                3:       ch[c] = 16'($urandom_range(4096));
                default: ch[c] = 16'($urandom_range(32768, 65535));
            endcase
        end
        offer_pixel(ch[0], ch[1], ch[2]);
    endtask

    // drop valid, then hold until every pixel in flight has come back
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_pix.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [2:0] idx, input logic [47:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
    endtask

    task automatic cfg_end();
        i_cfg_valid <= 1'b0;
    endtask

    task automatic pick_settings();
        logic [47:0] bl, sc, cp;
        logic [15:0] w, th;
        logic [63:0] rc;
        for (int c = 0; c < NUM_CH; c++) begin
            bl[16*c +: 16] = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                                      : 16'($urandom_range(2048));
            sc[16*c +: 16] = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                                      : 16'($urandom_range(3000, 12000));
            cp[16*c +: 16] = 16'($urandom_range(65535));
        end
        w  = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                      : 16'(32'hFFFF - $urandom_range(8000));
        th = ($urandom_range(1) == 0) ? 16'((32'(w) * 9) / 10)
                                      : 16'($urandom_range(32'(w)));
        if (w > th && $urandom_range(7) != 0)
            rc = (64'd1 << 32) / 64'(w - th);
        else
            rc = 64'($urandom);
        if (rc > 64'hFFFF_FFFF)
            rc = 64'hFFFF_FFFF;
        set_reg(CFG_BLACK, bl);
        set_reg(CFG_SCALE, sc);
        set_reg(CFG_CAP, cp);
        set_reg(CFG_WHITE, 48'(w));
        set_reg(CFG_SAT, 48'(($urandom_range(7) == 0) ? CH_NONE : 2'($urandom_range(2))));
        set_reg(CFG_THRESH, 48'(th));
        set_reg(CFG_RECIP, 48'(rc[31:0]));
        cfg_end();
    endtask

    task automatic test_reset_levels();
        offer_pixel(16'h0000, 16'h0000, 16'h0000);
        offer_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        offer_pixel(16'h1234, 16'h8000, 16'd58981);
        offer_pixel(16'hFFFF, 16'h0000, 16'd58982);
        offer_pixel(16'hFFFF, 16'hAAAA, 16'd62000);
        wait_idle();
        set_reg(CFG_CAP, 48'h0000_1000_0800);
        cfg_end();
        offer_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        offer_pixel(16'hF000, 16'h5555, 16'd61000);
        offer_pixel(16'h0000, 16'h0800, 16'hFFFF);
        wait_idle();
    endtask

    task automatic test_sat_select();
        set_reg(CFG_SAT, 48'(CH0));
        cfg_end();
        offer_pixel(16'hFFFF, 16'hF000, 16'h1234);
        wait_idle();
        set_reg(CFG_SAT, 48'(CH1));
        cfg_end();
        offer_pixel(16'h8000, 16'hFFFF, 16'hC000);
        wait_idle();
        // all-ones data truncates to the no-channel selector
        set_reg(CFG_SAT, '1);
        cfg_end();
        offer_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        wait_idle();
    endtask

    task automatic test_black_scale_white();
        set_reg(CFG_BLACK, 48'hFFFF_2000_1000);
        set_reg(CFG_SCALE, 48'h1000_0000_FFFF);
        set_reg(CFG_CAP, 48'h4000_4000_0000);
        set_reg(CFG_WHITE, 48'hABCD_0000_8000);
        set_reg(CFG_SAT, 48'(CH0));
        set_reg(CFG_THRESH, 48'h7000);
        set_reg(CFG_RECIP, 48'h0010_0000);
        cfg_end();
        offer_pixel(16'h0FFF, 16'h1FFF, 16'hFFFF);
        offer_pixel(16'h1000, 16'h2000, 16'hFFFE);
        offer_pixel(16'h1001, 16'h2001, 16'hFFFF);
        offer_pixel(16'h1800, 16'hFFFF, 16'h0000);
        offer_pixel(16'hFFFF, 16'h4321, 16'h8000);
        wait_idle();
        set_reg(CFG_WHITE, 48'h0);
        set_reg(CFG_THRESH, 48'h0);
        cfg_end();
        offer_pixel(16'hFFFF, 16'h1234, 16'hFFFF);
        wait_idle();
    endtask

    task automatic test_recip_extremes();
        set_reg(CFG_BLACK, RST_BLACK);
        set_reg(CFG_SCALE, RST_SCALE);
        set_reg(CFG_WHITE, 48'(RST_WHITE));
        set_reg(CFG_SAT, 48'(CH2));
        set_reg(CFG_CAP, 48'h0300_0200_0100);
        set_reg(CFG_RECIP, 48'hFFFF_FFFF);
        cfg_end();
        offer_pixel(16'hFFFF, 16'h8000, 16'h0001);
        wait_idle();
        set_reg(CFG_RECIP, 48'h0);
        set_reg(CFG_SPARE, '1);
        cfg_end();
        offer_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        wait_idle();
        set_reg(CFG_THRESH, 48'hFFFF);
        set_reg(CFG_RECIP, 48'hFFFF_FFFF);
        cfg_end();
        offer_pixel(16'h0000, 16'h0000, 16'hFFFF);
        offer_pixel(16'h7FFF, 16'hFFFF, 16'hFFFE);
        wait_idle();
    endtask

    task automatic test_random_stream();
        int src_pct[4]  = '{0, 78, 0, 8};
        int sink_pct[4] = '{0, 0, 78, 8};
        for (int ph = 0; ph < 4; ph++) begin
            pick_settings();
            src_idle_pct   = src_pct[ph];
            sink_stall_pct = sink_pct[ph];
            repeat (PHASE_PIX)
                offer_random_pixel();
            wait_idle();
        end
        src_idle_pct   = 0;
        sink_stall_pct = 0;
    endtask

    task automatic test_output_backpressure();
        pick_settings();
        hold_reqs++;
        repeat (60)
            offer_random_pixel();
        wait_idle();
    endtask

    initial begin
        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_levels();
        test_sat_select();
        test_black_scale_white();
        test_recip_extremes();
        test_random_stream();
        test_output_backpressure();
        wait_idle();
        repeat (PIPE_DEPTH + 8) @(posedge i_clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
